// File: hw/rtl/dplt_pkg.sv
// ----------------------------------------------------------------------------
// dplt_pkg: shared constants for the demand paging LRU translator
// Sizes of the page tables, frame map and use stamps, plus reset values.
// ----------------------------------------------------------------------------
package dplt_pkg;

  // Geometry
  localparam int unsigned PAGES       = 16;
  localparam int unsigned FRAMES      = 8;
  localparam int unsigned PROCESSES   = 2;
  localparam int unsigned OFFSET_BITS = 6;

  localparam int unsigned PAGE_W  = $clog2(PAGES);
  localparam int unsigned FRAME_W = $clog2(FRAMES);
  localparam int unsigned PID_W   = $clog2(PROCESSES);
  localparam int unsigned SLOT_W  = PID_W + PAGE_W;
  localparam int unsigned SLOTS   = PROCESSES * PAGES;

  // Port field widths
  localparam int unsigned ADDR_W = 10;
  localparam int unsigned PHYS_W = 9;
  localparam int unsigned TIME_W = 5;
  localparam int unsigned CFG_W  = 4;

  // Use stamps: time modulo 30, scan starts above any legal stamp
  localparam int unsigned STAMP_W    = 5;
  localparam int unsigned BEST_W     = STAMP_W + 1;
  localparam int unsigned STAMP_MOD  = 30;
  localparam int unsigned STAMP_NONE = 32;

  // Allocation limit after reset
  localparam int unsigned LIMIT_RESET = 6;

endpackage

// File: hw/rtl/demand_paging_lru_translator_core.sv
// ----------------------------------------------------------------------------
// demand_paging_lru_translator_core
// Per-process page tables with demand allocation and LRU page replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: valid_i / stall_o with process_id_i, logical_address_i and
//   time_now_i. A request is taken when valid_i is high and stall_o is low.
//   Output channel: valid_o / stall_i with the translation and fault flags,
//   held in an output register until taken.
//   Config: cfg_we_i writes cfg_data_i to the frame allocation limit; write
//   only while the block is idle. Values above 8 act as 8.
// Sequencing:
//   One request at a time; stall_o stays high until the result is written to
//   the output register. A hit goes from LOOKUP straight to FINISH. A miss
//   with a free frame runs the free-frame scan (FREE) until it finds a free
//   frame below the limit. A miss that needs replacement runs the free-frame
//   scan to the limit, then a stamp scan (SCAN) over the 16 page table
//   entries of the process, one entry per cycle, then the eviction (EVICT).
// Reset:
//   All pages non-present, all frames free, limit = 6.
// Back pressure:
//   While the output is stalled, a finished request waits in its last state
//   and the next request is not taken until the output register frees up.
// ----------------------------------------------------------------------------
module demand_paging_lru_translator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [dplt_pkg::CFG_W-1:0]     cfg_data_i,
  // input channel
  input  logic                           valid_i,
  output logic                           stall_o,
  input  logic [0:0]                     process_id_i,
  input  logic [dplt_pkg::ADDR_W-1:0]    logical_address_i,
  input  logic [dplt_pkg::TIME_W-1:0]    time_now_i,
  // output channel
  output logic                           valid_o,
  input  logic                           stall_i,
  output logic [dplt_pkg::PHYS_W-1:0]    physical_address_o,
  output logic                           page_fault_o,
  output logic                           evicted_o,
  output logic [dplt_pkg::PAGE_W-1:0]    evicted_page_o,
  output logic                           no_victim_o
);

  localparam int unsigned PAGE_W  = dplt_pkg::PAGE_W;
  localparam int unsigned FRAME_W = dplt_pkg::FRAME_W;
  localparam int unsigned SLOT_W  = dplt_pkg::SLOT_W;
  localparam int unsigned SLOTS   = dplt_pkg::SLOTS;
  localparam int unsigned FRAMES  = dplt_pkg::FRAMES;
  localparam int unsigned STAMP_W = dplt_pkg::STAMP_W;
  localparam int unsigned BEST_W  = dplt_pkg::BEST_W;
  localparam int unsigned OFF_W   = dplt_pkg::OFFSET_BITS;
  localparam int unsigned CNT_W   = FRAME_W + 1;
  localparam int unsigned CFG_W   = dplt_pkg::CFG_W;
  localparam int unsigned TIME_W  = dplt_pkg::TIME_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOKUP = 3'd1;
  localparam logic [2:0] ST_FREE   = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_EVICT  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_q, state_d;

  // Tables
  logic [SLOTS-1:0]   present_q;
  logic [FRAME_W-1:0] frame_q [SLOTS];
  logic [STAMP_W-1:0] stamp_q [SLOTS];
  logic [FRAMES-1:0]  taken_q;
  logic [dplt_pkg::CFG_W-1:0] limit_q;

  // Request context
  logic               pid_q;
  logic [PAGE_W-1:0]  page_q;
  logic [OFF_W-1:0]   offset_q;
  logic [STAMP_W-1:0] req_stamp_q;
  logic               fault_q;
  logic [FRAME_W-1:0] sel_frame_q, sel_frame_d;

  // Scan state
  logic [CNT_W-1:0]   fcnt_q, fcnt_d;
  logic [PAGE_W-1:0]  pcnt_q, pcnt_d;
  logic [BEST_W-1:0]  best_q, best_d;
  logic [PAGE_W-1:0]  victim_q, victim_d;
  logic               have_q, have_d;
  logic               ev_q, ev_d;
  logic               novic_q, novic_d;

  // Output register
  logic                      out_valid_q;
  logic [dplt_pkg::PHYS_W-1:0] out_phys_q;
  logic                      out_fault_q, out_ev_q, out_novic_q;
  logic [PAGE_W-1:0]         out_evpage_q;

  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  scan_idx;
  logic [SLOT_W-1:0]  victim_idx;
  logic [CNT_W-1:0]   limit_eff;
  logic               in_fire, out_free;
  logic [STAMP_W-1:0] in_stamp;

  assign slot       = {pid_q, page_q};
  assign scan_idx   = {pid_q, pcnt_q};
  assign victim_idx = {pid_q, victim_q};
  assign in_fire    = valid_i && !stall_o;
  assign out_free   = !(out_valid_q && stall_i);
  assign stall_o    = (state_q != ST_IDLE);

  // Saturate the allocation limit to the frame count
  assign limit_eff = (limit_q > CFG_W'(FRAMES)) ? CNT_W'(FRAMES) : CNT_W'(limit_q);

  // Stamp = time modulo 30 (input is below twice the modulus)
  assign in_stamp = (time_now_i >= TIME_W'(dplt_pkg::STAMP_MOD))
                  ? STAMP_W'(time_now_i - TIME_W'(dplt_pkg::STAMP_MOD))
                  : STAMP_W'(time_now_i);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    fcnt_d      = fcnt_q;
    pcnt_d      = pcnt_q;
    best_d      = best_q;
    victim_d    = victim_q;
    have_d      = have_q;
    ev_d        = ev_q;
    novic_d     = novic_q;
    sel_frame_d = sel_frame_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        ev_d     = 1'b0;
        novic_d  = 1'b0;
        fcnt_d   = '0;
        pcnt_d   = '0;
        best_d   = BEST_W'(dplt_pkg::STAMP_NONE);
        victim_d = '0;
        have_d   = 1'b0;
        if (present_q[slot]) begin
          sel_frame_d = frame_q[slot];
          state_d     = ST_FINISH;
        end else begin
          state_d = ST_FREE;
        end
      end
      ST_FREE: begin
        if (fcnt_q >= limit_eff) begin
          state_d = ST_SCAN;
        end else if (!taken_q[fcnt_q[FRAME_W-1:0]]) begin
          sel_frame_d = fcnt_q[FRAME_W-1:0];
          state_d     = ST_FINISH;
        end else begin
          fcnt_d = fcnt_q + CNT_W'(1);
        end
      end
      ST_SCAN: begin
        if (present_q[scan_idx] && (BEST_W'(stamp_q[scan_idx]) < best_q)) begin
          best_d   = BEST_W'(stamp_q[scan_idx]);
          victim_d = pcnt_q;
          have_d   = 1'b1;
        end
        pcnt_d = pcnt_q + PAGE_W'(1);
        if (pcnt_q == PAGE_W'(dplt_pkg::PAGES - 1)) begin
          state_d = ST_EVICT;
        end
      end
      ST_EVICT: begin
        if (have_q) begin
          sel_frame_d = frame_q[victim_idx];
          ev_d        = 1'b1;
        end else begin
          novic_d = 1'b1;
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= CFG_W'(dplt_pkg::LIMIT_RESET);
      present_q   <= '0;
      taken_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      // Frame allocated from the free list
      if (state_q == ST_FREE && fcnt_q < limit_eff && !taken_q[fcnt_q[FRAME_W-1:0]]) begin
        taken_q[fcnt_q[FRAME_W-1:0]] <= 1'b1;
      end
      // Victim loses its frame
      if (state_q == ST_EVICT && have_q) begin
        present_q[victim_idx] <= 1'b0;
      end
      if (state_q == ST_FINISH && out_free && !novic_q) begin
        present_q[slot] <= 1'b1;
      end
      // Output handshake
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fcnt_q      <= fcnt_d;
    pcnt_q      <= pcnt_d;
    best_q      <= best_d;
    victim_q    <= victim_d;
    have_q      <= have_d;
    ev_q        <= ev_d;
    novic_q     <= novic_d;
    sel_frame_q <= sel_frame_d;
    if (in_fire) begin
      pid_q       <= process_id_i;
      page_q      <= logical_address_i[OFF_W +: PAGE_W];
      offset_q    <= logical_address_i[OFF_W-1:0];
      req_stamp_q <= in_stamp;
    end
    if (state_q == ST_LOOKUP) begin
      fault_q <= !present_q[slot];
    end
    // Table update and result capture
    if (state_q == ST_FINISH && out_free) begin
      if (!novic_q) begin
        frame_q[slot] <= sel_frame_q;
        stamp_q[slot] <= req_stamp_q;
      end
      out_phys_q   <= novic_q ? '0 : {sel_frame_q, offset_q};
      out_fault_q  <= fault_q;
      out_ev_q     <= ev_q;
      out_evpage_q <= ev_q ? victim_q : '0;
      out_novic_q  <= novic_q;
    end
  end

  assign valid_o            = out_valid_q;
  assign physical_address_o = out_phys_q;
  assign page_fault_o       = out_fault_q;
  assign evicted_o          = out_ev_q;
  assign evicted_page_o     = out_evpage_q;
  assign no_victim_o        = out_novic_q;

  // Assertions
  // Resident page count equals taken frame count outside FINISH (the new page
  // is marked present only when its request finishes)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FINISH) |-> ($countones(present_q) == $countones(taken_q)))
    else $error("resident page count differs from taken frame count");

  // An eviction or a missing victim only happens on a fault
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (evicted_o || no_victim_o) |-> page_fault_o)
    else $error("eviction flag without page fault");

  // No victim result carries a zero address and no eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && no_victim_o |-> !evicted_o && physical_address_o == '0)
    else $error("bad no-victim result");

  // A taken request blocks the input until its result is written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> stall_o)
    else $error("input not stalled after request");

endmodule
